// ----- rtl/sdcp_pkg.sv -----
// Shared constants, command codes and the queue entry type of the serial drive
// command parser. Has no dependencies; every module of the block imports it.
package sdcp_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int FIELD_COUNT = 5;
  localparam int STATE_WIDTH = 3;
  localparam int IDX_WIDTH   = 3;
  localparam int EVENT_WIDTH = 2;
  localparam int TURN_COUNT  = 4;
  localparam int TURN_IDX_W  = $clog2(TURN_COUNT);
  localparam int SPEED_FIELD = TURN_COUNT;

  // Received characters that carry a meaning.
  localparam logic [7:0] CH_REPORT = 8'h3F;
  localparam logic [7:0] CH_START  = 8'h46;
  localparam logic [7:0] CH_STOP   = 8'h53;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Command codes passed from the front end to the execution side.
  localparam logic [2:0] OP_STOP   = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_REPORT = 3'd2;
  localparam logic [2:0] OP_OPEN   = 3'd3;
  localparam logic [2:0] OP_DIGIT  = 3'd4;
  localparam logic [2:0] OP_COLON  = 3'd5;
  localparam logic [2:0] OP_CLOSE  = 3'd6;

  // Result event codes.
  localparam logic [EVENT_WIDTH-1:0] EV_WRITE_STATE = 2'd0;
  localparam logic [EVENT_WIDTH-1:0] EV_REPORT      = 2'd1;
  localparam logic [EVENT_WIDTH-1:0] EV_PARAMS      = 2'd2;

  // Register addresses.
  localparam int         PADDR_WIDTH   = 3;
  localparam logic [PADDR_WIDTH-1:0] ADDR_STOPPED = 3'd0;

  typedef struct packed {
    logic [2:0]             op;
    logic [3:0]             digit;
    logic [STATE_WIDTH-1:0] drive;
    logic [STATE_WIDTH-1:0] stop_code;
  } op_t;

endpackage

// ----- rtl/sdcp_front.sv -----
// Front end: accepts received bytes, tracks whether a list is open and turns
// each byte with an effect into a command for the queue. Depends on sdcp_pkg.
module sdcp_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      rx_byte,
  input  logic [sdcp_pkg::STATE_WIDTH-1:0] drive_state,
  input  logic [sdcp_pkg::STATE_WIDTH-1:0] stopped_code,
  input  logic                            q_full,
  output logic                            push,
  output sdcp_pkg::op_t                   push_op
);
  import sdcp_pkg::*;

  logic in_list;
  logic in_list_next;
  logic take;
  logic useful;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  always_comb begin
    useful            = 1'b0;
    in_list_next      = in_list;
    push_op.op        = OP_REPORT;
    push_op.digit     = 4'(rx_byte - CH_ZERO);
    push_op.drive     = drive_state;
    push_op.stop_code = stopped_code;
    if (in_list) begin
      if (rx_byte >= CH_ZERO && rx_byte <= CH_NINE) begin
        useful     = 1'b1;
        push_op.op = OP_DIGIT;
      end else if (rx_byte == CH_COLON) begin
        useful     = 1'b1;
        push_op.op = OP_COLON;
      end else if (rx_byte == CH_CLOSE) begin
        useful       = 1'b1;
        push_op.op   = OP_CLOSE;
        in_list_next = 1'b0;
      end
    end else begin
      unique case (rx_byte)
        CH_STOP: begin
          useful     = (drive_state != stopped_code);
          push_op.op = OP_STOP;
        end
        CH_START: begin
          useful     = 1'b1;
          push_op.op = OP_START;
        end
        CH_REPORT: begin
          useful     = 1'b1;
          push_op.op = OP_REPORT;
        end
        CH_OPEN: begin
          useful       = 1'b1;
          push_op.op   = OP_OPEN;
          in_list_next = 1'b1;
        end
        default: useful = 1'b0;
      endcase
    end
  end

  assign push = take && useful;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_list <= 1'b0;
    end else if (take) begin
      in_list <= in_list_next;
    end
  end

endmodule

// ----- rtl/sdcp_queue.sv -----
// Two-entry command queue between the front end and the execution side.
// Depends on sdcp_pkg for the entry type.
module sdcp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sdcp_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output sdcp_pkg::op_t head_op
);
  import sdcp_pkg::*;

  op_t        slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_op    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/sdcp_back.sv -----
// Execution side: holds the saved drive state and the list values, carries out
// one command per cycle unless a held result waits on out_ready, and keeps the
// result in an output register. Depends on sdcp_pkg.
module sdcp_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 head_valid,
  input  sdcp_pkg::op_t                        head_op,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [sdcp_pkg::EVENT_WIDTH-1:0]     event_res,
  output logic [sdcp_pkg::STATE_WIDTH-1:0]     new_state,
  output logic [sdcp_pkg::VALUE_WIDTH-1:0]     speed_step_one,
  output logic [sdcp_pkg::VALUE_WIDTH-1:0]     angle_step_one,
  output logic [sdcp_pkg::VALUE_WIDTH-1:0]     speed_step_two,
  output logic [sdcp_pkg::VALUE_WIDTH-1:0]     angle_step_two,
  output logic [sdcp_pkg::VALUE_WIDTH-1:0]     cruise_speed
);
  import sdcp_pkg::*;

  localparam int WIDE = VALUE_WIDTH + 4;
  localparam logic [WIDE-1:0] VMAX = WIDE'({VALUE_WIDTH{1'b1}});

  logic [STATE_WIDTH-1:0] saved_drive;
  logic [IDX_WIDTH-1:0]   field_index;
  logic [VALUE_WIDTH-1:0] turn_values [TURN_COUNT];
  logic [VALUE_WIDTH-1:0] speed_value;

  logic [VALUE_WIDTH-1:0] cur_value;
  logic [WIDE-1:0]        scaled;
  logic [VALUE_WIDTH-1:0] digit_value;
  logic [IDX_WIDTH-1:0]   next_index;
  logic                   colon_moves;
  logic                   has_result;

  assign pop = head_valid && (!out_valid || out_ready);

  always_comb begin
    if (field_index < IDX_WIDTH'(TURN_COUNT)) begin
      cur_value = turn_values[field_index[TURN_IDX_W-1:0]];
    end else if (field_index == IDX_WIDTH'(SPEED_FIELD)) begin
      cur_value = speed_value;
    end else begin
      cur_value = '0;
    end
  end

  // Times ten plus the digit as a shift-and-add, then saturation at the field width.
  assign scaled = {1'b0, cur_value, 3'b000} + {3'b000, cur_value, 1'b0}
                  + WIDE'(head_op.digit);
  assign digit_value = (scaled > VMAX) ? {VALUE_WIDTH{1'b1}} : scaled[VALUE_WIDTH-1:0];

  assign next_index  = field_index + IDX_WIDTH'(1);
  assign colon_moves = (32'(field_index) + 32'd1 < 32'(FIELD_COUNT))
                       && (field_index != {IDX_WIDTH{1'b1}});

  always_comb begin
    unique case (head_op.op)
      OP_STOP, OP_START, OP_REPORT, OP_CLOSE: has_result = 1'b1;
      default:                                has_result = 1'b0;
    endcase
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      saved_drive <= '0;
      field_index <= '0;
      speed_value <= '0;
      for (int i = 0; i < TURN_COUNT; i++) begin
        turn_values[i] <= '0;
      end
    end else if (pop) begin
      unique case (head_op.op)
        OP_STOP: saved_drive <= head_op.drive;
        OP_OPEN: begin
          speed_value    <= '0;
          field_index    <= '0;
          turn_values[0] <= '0;
        end
        OP_DIGIT: begin
          if (field_index < IDX_WIDTH'(TURN_COUNT)) begin
            turn_values[field_index[TURN_IDX_W-1:0]] <= digit_value;
          end else if (field_index == IDX_WIDTH'(SPEED_FIELD)) begin
            speed_value <= digit_value;
          end
        end
        OP_COLON: begin
          if (colon_moves) begin
            field_index <= next_index;
            if (next_index < IDX_WIDTH'(TURN_COUNT)) begin
              turn_values[next_index[TURN_IDX_W-1:0]] <= '0;
            end else if (next_index == IDX_WIDTH'(SPEED_FIELD)) begin
              speed_value <= '0;
            end
          end
        end
        default: saved_drive <= saved_drive;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && has_result) begin
      new_state      <= '0;
      speed_step_one <= '0;
      angle_step_one <= '0;
      speed_step_two <= '0;
      angle_step_two <= '0;
      cruise_speed   <= '0;
      unique case (head_op.op)
        OP_STOP: begin
          event_res <= EV_WRITE_STATE;
          new_state <= head_op.stop_code;
        end
        OP_START: begin
          event_res <= EV_WRITE_STATE;
          new_state <= saved_drive;
        end
        OP_REPORT: event_res <= EV_REPORT;
        default: begin
          event_res      <= EV_PARAMS;
          speed_step_one <= turn_values[0];
          angle_step_one <= turn_values[1];
          speed_step_two <= turn_values[2];
          angle_step_two <= turn_values[3];
          cruise_speed   <= speed_value;
        end
      endcase
    end
  end

endmodule

// ----- rtl/serial_drive_command_parser_core.sv -----
// Top level of the serial drive command parser: register port, front end,
// command queue and execution side. Depends on sdcp_pkg, sdcp_front,
// sdcp_queue and sdcp_back.
//
//   Channel   Handshake               Payload
//   ------    ---------------------   --------------------------------------
//   input     in_valid / in_ready     rx_byte, drive_state
//   output    out_valid / out_ready   event_res, new_state, speed_step_one,
//                                     angle_step_one, speed_step_two,
//                                     angle_step_two, cruise_speed
//   config    psel/penable/pready     paddr, pwrite, pwdata, prdata
//
// Each byte is decoded combinationally in the front end and, if useful, put into the
// queue; the execution side takes it from the queue head and registers the
// result. One byte per cycle is sustained while the output is not stalled.
// Reset is synchronous and clears the list state, the saved drive state, all
// values and the queue; the stopped code returns to 7. A stall on the output
// fills the output register and then the two-entry queue; only then does
// in_ready drop. Until then, bytes that cause no work are taken and use no entry.
module serial_drive_command_parser_core (
  input  logic                                 clk,
  input  logic                                 rst,
  // Received byte channel.
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           rx_byte,
  input  logic [sdcp_pkg::STATE_WIDTH-1:0]     drive_state,
  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [sdcp_pkg::EVENT_WIDTH-1:0]     event_res,
  output logic [sdcp_pkg::STATE_WIDTH-1:0]     new_state,
  output logic [sdcp_pkg::VALUE_WIDTH-1:0]     speed_step_one,
  output logic [sdcp_pkg::VALUE_WIDTH-1:0]     angle_step_one,
  output logic [sdcp_pkg::VALUE_WIDTH-1:0]     speed_step_two,
  output logic [sdcp_pkg::VALUE_WIDTH-1:0]     angle_step_two,
  output logic [sdcp_pkg::VALUE_WIDTH-1:0]     cruise_speed,
  // Register port.
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sdcp_pkg::PADDR_WIDTH-1:0]     paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import sdcp_pkg::*;

  logic [STATE_WIDTH-1:0] stopped_code;
  logic                   push;
  op_t                    push_op;
  logic                   q_full;
  logic                   pop;
  logic                   head_valid;
  op_t                    head_op;

  // The register port never waits. The user must write the stopped code only while
  // block is idle (not enforced), so the front end may sample it as each byte arrives.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stopped_code <= 3'd7;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_STOPPED) begin
      stopped_code <= pwdata[STATE_WIDTH-1:0];
    end
  end

  assign prdata = (paddr == ADDR_STOPPED) ? 32'(stopped_code) : 32'd0;

  // The front end decides what each byte means and drops bytes with no effect.
  sdcp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .drive_state  (drive_state),
    .stopped_code (stopped_code),
    .q_full       (q_full),
    .push         (push),
    .push_op      (push_op)
  );

  sdcp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  // The execution side updates the list values and builds each result transfer.
  sdcp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_op        (head_op),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_res      (event_res),
    .new_state      (new_state),
    .speed_step_one (speed_step_one),
    .angle_step_one (angle_step_one),
    .speed_step_two (speed_step_two),
    .angle_step_two (angle_step_two),
    .cruise_speed   (cruise_speed)
  );

endmodule
